/* rtl/fpsr_pkg.sv */
// ----------------------------------------------------------------------------
// fpsr_pkg
// Shared constants and types for the pipelined fixed-point square root.
// ----------------------------------------------------------------------------
package fpsr_pkg;

  localparam int FRAC_BITS = 16;             // fraction bits of operand and root
  localparam int OP_W      = 32;             // operand width
  localparam int ROOT_W    = 24;             // root field width
  localparam int X_W       = 64;             // radicand width (operand << FRAC_BITS)
  localparam int N_ITER    = X_W / 2;        // one root bit per bit pair
  localparam int Q_W       = N_ITER;         // partial root width
  localparam int REM_W     = Q_W + 2;        // partial remainder width

  localparam logic [ROOT_W-1:0] ROOT_MAX = {ROOT_W{1'b1}};

  // Payload carried from one iteration stage to the next
  typedef struct packed {
    logic [X_W-1:0]   x;    // radicand bits not yet consumed, top-aligned
    logic [REM_W-1:0] rem;  // partial remainder
    logic [Q_W-1:0]   q;    // partial root
  } sq_data_t;

endpackage

/* rtl/fpsr_skid.sv */
// ----------------------------------------------------------------------------
// fpsr_skid
// Input skid register: takes one item while the pipeline is stalled so the
// input ready is a register and never waits on the output side.
// ----------------------------------------------------------------------------
module fpsr_skid import fpsr_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [OP_W-1:0] in_tdata,
  input  logic            adv,        // pipeline advances this cycle
  output logic            src_valid,
  output logic [OP_W-1:0] src_data
);

  logic            skid_v_r;
  logic            skid_v_nxt;
  logic [OP_W-1:0] skid_d_r;

  assign in_tready = !skid_v_r;
  assign src_valid = skid_v_r || in_tvalid;
  assign src_data  = skid_v_r ? skid_d_r : in_tdata;

  always_comb begin
    skid_v_nxt = skid_v_r;
    if (adv) begin
      skid_v_nxt = 1'b0;
    end else if (in_tvalid && !skid_v_r) begin
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else begin
      skid_v_r <= skid_v_nxt;
    end
  end

  // hold the captured item until the pipeline takes it
  always_ff @(posedge clk) begin
    if (!adv && in_tvalid && !skid_v_r) begin
      skid_d_r <= in_tdata;
    end
  end

endmodule

/* rtl/fpsr_stage.sv */
// ----------------------------------------------------------------------------
// fpsr_stage
// One restoring square-root iteration: bring down a bit pair, trial subtract,
// decide one root bit, register the result.
// ----------------------------------------------------------------------------
module fpsr_stage import fpsr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  logic     valid_in,
  input  sq_data_t data_in,
  output logic     valid_out,
  output sq_data_t data_out
);

  logic             valid_r;
  sq_data_t         data_r;
  sq_data_t         data_nxt;
  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;
  logic             ge;

  always_comb begin
    rem_sh = {data_in.rem, data_in.x[X_W-1 -: 2]};
    trial  = {2'b00, data_in.q, 2'b01};
    diff   = rem_sh - trial;
    ge     = (rem_sh >= trial);
    data_nxt.rem = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
    data_nxt.q   = {data_in.q[Q_W-2:0], ge};
    data_nxt.x   = {data_in.x[X_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign valid_out = valid_r;
  assign data_out  = data_r;

endmodule

/* rtl/fixed_point_square_root.sv */
// Throughput: one item per cycle unless the output stalls; each of the 32 root
// bits has its own register stage, and results leave through the output register.
// Stalls freeze the whole pipeline; a one-entry input skid register keeps in_tready
// registered and takes one more item while a finished result waits.
// Reset (rst_n low, synchronous) clears all valid bits and the skid register;
// payload registers are not reset.
// ----------------------------------------------------------------------------
// fixed_point_square_root
// Streaming fixed-point square root, floor(sqrt(operand << FRAC_BITS)),
// zero for non-positive operands, saturated to the 24-bit root field.
// ----------------------------------------------------------------------------
module fixed_point_square_root import fpsr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [OP_W-1:0]   in_tdata,   // [31:0] operand (signed)
  // result channel
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [ROOT_W-1:0] out_tdata   // [23:0] root
);

  logic              adv;
  logic              src_valid;
  logic [OP_W-1:0]   src_data;
  logic              pos;
  sq_data_t          head;
  logic              stg_valid [N_ITER+1];
  sq_data_t          stg_data  [N_ITER+1];
  logic              out_valid_r;
  logic [ROOT_W-1:0] out_root_r;
  logic [ROOT_W-1:0] root_nxt;

  // Advance the whole pipeline unless a finished item sits unclaimed at the output.
  assign adv = !out_valid_r || out_tready;

  fpsr_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .adv       (adv),
    .src_valid (src_valid),
    .src_data  (src_data)
  );

  // Positive means sign clear and not zero; anything else enters as a zero
  // radicand, which walks through the iterations to a zero root.
  always_comb begin
    pos      = !src_data[OP_W-1] && (src_data != '0);
    head.x   = pos ? (X_W'({{(X_W-OP_W){1'b0}}, src_data}) << FRAC_BITS) : '0;
    head.rem = '0;
    head.q   = '0;
  end

  assign stg_valid[0] = src_valid;
  assign stg_data[0]  = head;

  // One stage per root bit, most significant bit pair first.
  for (genvar i = 0; i < N_ITER; i++) begin : g_iter
    fpsr_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .valid_in  (stg_valid[i]),
      .data_in   (stg_data[i]),
      .valid_out (stg_valid[i+1]),
      .data_out  (stg_data[i+1])
    );
  end

  // Saturate roots that overflow the field (only possible with many fraction bits).
  always_comb begin
    if (stg_data[N_ITER].q > Q_W'(ROOT_MAX)) begin
      root_nxt = ROOT_MAX;
    end else begin
      root_nxt = stg_data[N_ITER].q[ROOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= stg_valid[N_ITER];
    end
  end

  // Hold the result while the consumer stalls.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_root_r <= root_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_root_r;

endmodule

/* rtl/fpsr_checker.sv */
// ----------------------------------------------------------------------------
// fpsr_checker
// Port-level checks for the fixed-point square root, bound to the top level.
// ----------------------------------------------------------------------------
module fpsr_checker import fpsr_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [OP_W-1:0]   in_tdata,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [ROOT_W-1:0] out_tdata
);

  // An accepted operand carries no unknown bits.
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> !$isunknown(in_tdata))
    else $error("accepted operand has unknown bits");

  // A stalled result stays and keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or vanished while stalled");

  // The input only backs off after the output side stalled.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> $past(out_tvalid && !out_tready))
    else $error("in_tready low without an output stall");

  // Once the output drains, the input side opens again in the next cycle.
  a_ready_recover: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready && out_tready |=> in_tready)
    else $error("in_tready stuck low after output drained");

endmodule

bind fixed_point_square_root fpsr_checker u_fpsr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
